### sv/ascon_pkg.sv
// ============================================================================
// ascon_pkg
// Shared types, codes, constants and helper functions of the Ascon-128 core.
// ============================================================================
package ascon_pkg;

  typedef logic [63:0] lane_t;
  typedef lane_t [4:0] lanes_t;

  localparam int unsigned NumRounds   = 12;
  localparam int unsigned RoundIdxW   = $clog2(NumRounds);
  localparam int unsigned DataRounds  = 6;

  typedef logic [RoundIdxW-1:0] round_idx_t;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_AD    = 2'd1,
    CMD_MSG   = 2'd2
  } cmd_t;

  localparam lane_t ASCON_IV = 64'h8040_0c06_0000_0000;

  // Round constants, indexed by the absolute round number.
  localparam logic [7:0] RC_TABLE [NumRounds] = '{
    8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
  };

  // Mask that keeps the first n bytes (most significant first).
  function automatic lane_t byte_mask(logic [2:0] n);
    return ~({64{1'b1}} >> {n, 3'b000});
  endfunction

  // Single padding bit right after the first n bytes.
  function automatic lane_t pad_bit(logic [2:0] n);
    return 64'h8000_0000_0000_0000 >> {n, 3'b000};
  endfunction

endpackage

### sv/ascon128_aead_core_top.sv
// ============================================================================
// ascon128_aead_core_top
// Ascon-128 AEAD core: one shared round unit stepped by a small sequencer.
// ============================================================================
// Rounds: an associated data block or a non-last message block runs 6 rounds;
// a start request and a last message block run 12. Ignored requests skip the
// rounds. A new request is taken only once the last result has gone to the
// output register; the single round unit runs one round per cycle. rst is
// synchronous and active high; it returns the sequencer to idle, clears the
// key and the phase, and empties the output.
// ============================================================================
module ascon128_aead_core_top
  import ascon_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic        decrypt_mode,
  input  logic [63:0] nonce_high,
  input  logic [63:0] nonce_low,
  input  logic [63:0] block_data,
  input  logic        is_last,
  input  logic [2:0]  last_bytes,
  input  logic [63:0] expected_tag_high,
  input  logic [63:0] expected_tag_low,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] data_out,
  output logic [3:0]  data_bytes,
  output logic [63:0] tag_high,
  output logic [63:0] tag_low,
  output logic        tag_valid,
  output logic        tag_match
);

  // Sequencer: IDLE takes a request, PERM runs the shared round unit once per
  // cycle, EMIT applies the closing key or domain step and hands the result
  // to the output register as soon as that register is free.
  typedef enum logic [1:0] {
    S_IDLE,
    S_PERM,
    S_EMIT
  } state_t;

  // Protocol phase of the current message.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AD   = 2'd1,
    PH_MSG  = 2'd2
  } phase_t;

  // Step applied to the state after the permutation.
  typedef enum logic [1:0] {
    POST_NONE,
    POST_KEY,
    POST_DOMAIN,
    POST_TAG
  } post_t;

  localparam logic [3:0] FullBytes = 4'd8;

  state_t      state;
  phase_t      phase;
  logic        mode_is_decrypt;
  logic [63:0] key_high;
  logic [63:0] key_low;
  lanes_t      lanes;
  round_idx_t  round_idx;
  post_t       post;
  logic [63:0] res_data;
  logic [3:0]  res_bytes;
  logic [63:0] exp_high;
  logic [63:0] exp_low;

  logic        accept;
  logic        emit;

  // Values decided at acceptance.
  lanes_t      lanes_load;
  logic        go_perm;
  round_idx_t  start_idx;
  post_t       post_load;
  phase_t      phase_next;
  logic        mode_next;
  logic [63:0] data_load;
  logic [3:0]  bytes_load;

  // Values of the closing step.
  lanes_t      lanes_post;
  logic        tag_match_next;

  lanes_t      round_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign emit     = (state == S_EMIT) && (!out_valid || !out_stall);

  ascon_round u_round (
    .lanes_in  (lanes),
    .rc        (RC_TABLE[round_idx]),
    .lanes_out (round_out)
  );

  // Decode the request and prepare the state that the rounds start from.
  always_comb begin
    lane_t m;
    lane_t pad;
    lane_t blk;
    m          = byte_mask(last_bytes);
    pad        = pad_bit(last_bytes);
    blk        = block_data;
    lanes_load = lanes;
    go_perm    = 1'b0;
    start_idx  = round_idx_t'(NumRounds - DataRounds);
    post_load  = POST_NONE;
    phase_next = phase;
    mode_next  = mode_is_decrypt;
    data_load  = '0;
    bytes_load = '0;
    unique case (command)
      CMD_START: begin
        lanes_load = {nonce_low, nonce_high, key_low, key_high, ASCON_IV};
        go_perm    = 1'b1;
        start_idx  = '0;
        post_load  = POST_KEY;
        phase_next = PH_AD;
        mode_next  = decrypt_mode;
      end
      CMD_AD: begin
        if (phase == PH_AD) begin
          if (is_last) begin
            blk       = (block_data & m) | pad;
            post_load = POST_DOMAIN;
            phase_next = PH_MSG;
          end
          lanes_load[0] = lanes[0] ^ blk;
          go_perm       = 1'b1;
        end
      end
      CMD_MSG: begin
        if (phase != PH_IDLE) begin
          // Domain separation when no last associated data block closed the AD phase.
          if (phase == PH_AD) begin
            lanes_load[4] = lanes[4] ^ 64'd1;
          end
          go_perm = 1'b1;
          if (!is_last) begin
            if (mode_is_decrypt) begin
              data_load     = lanes[0] ^ block_data;
              lanes_load[0] = block_data;
            end else begin
              data_load     = lanes[0] ^ block_data;
              lanes_load[0] = lanes[0] ^ block_data;
            end
            bytes_load = FullBytes;
            phase_next = PH_MSG;
          end else begin
            if (mode_is_decrypt) begin
              data_load     = (lanes[0] ^ block_data) & m;
              lanes_load[0] = ((lanes[0] & ~m) | (block_data & m)) ^ pad;
            end else begin
              data_load     = (lanes[0] ^ (block_data & m)) & m;
              lanes_load[0] = lanes[0] ^ ((block_data & m) | pad);
            end
            lanes_load[1] = lanes[1] ^ key_high;
            lanes_load[2] = lanes[2] ^ key_low;
            bytes_load    = {1'b0, last_bytes};
            start_idx     = '0;
            post_load     = POST_TAG;
            phase_next    = PH_IDLE;
          end
        end
      end
      default: begin
        // Unused command code: no change, all-zero result.
      end
    endcase
  end

  // Closing step after the last round.
  always_comb begin
    lanes_post = lanes;
    unique case (post)
      POST_KEY, POST_TAG: begin
        lanes_post[3] = lanes[3] ^ key_high;
        lanes_post[4] = lanes[4] ^ key_low;
      end
      POST_DOMAIN: begin
        lanes_post[4] = lanes[4] ^ 64'd1;
      end
      default: begin
      end
    endcase
    tag_match_next = mode_is_decrypt && (lanes_post[3] == exp_high)
                     && (lanes_post[4] == exp_low);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_IDLE;
      mode_is_decrypt <= 1'b0;
      key_high        <= '0;
      key_low         <= '0;
      out_valid       <= 1'b0;
      round_idx       <= '0;
      post            <= POST_NONE;
    end else begin
      if (cfg_we) begin
        if (cfg_index) begin
          key_low <= cfg_data;
        end else begin
          key_high <= cfg_data;
        end
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lanes           <= lanes_load;
            round_idx       <= start_idx;
            post            <= post_load;
            phase           <= phase_next;
            mode_is_decrypt <= mode_next;
            res_data        <= data_load;
            res_bytes       <= bytes_load;
            exp_high        <= expected_tag_high;
            exp_low         <= expected_tag_low;
            state           <= go_perm ? S_PERM : S_EMIT;
          end
        end
        S_PERM: begin
          lanes     <= round_out;
          round_idx <= round_idx + round_idx_t'(1);
          if (round_idx == round_idx_t'(NumRounds - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            lanes      <= lanes_post;
            out_valid  <= 1'b1;
            data_out   <= res_data;
            data_bytes <= res_bytes;
            if (post == POST_TAG) begin
              tag_high  <= lanes_post[3];
              tag_low   <= lanes_post[4];
              tag_valid <= 1'b1;
              tag_match <= tag_match_next;
            end else begin
              tag_high  <= '0;
              tag_low   <= '0;
              tag_valid <= 1'b0;
              tag_match <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/ascon_round.sv
// ============================================================================
// ascon_round
// One Ascon permutation round: constant addition, S-box layer, linear layer.
// ============================================================================
module ascon_round
  import ascon_pkg::*;
(
  input  lanes_t     lanes_in,
  input  logic [7:0] rc,
  output lanes_t     lanes_out
);

  function automatic lane_t ror64(lane_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  always_comb begin
    lane_t s0, s1, s2, s3, s4;
    lane_t t0, t1, t2, t3, t4;
    s0 = lanes_in[0];
    s1 = lanes_in[1];
    s2 = lanes_in[2] ^ {56'd0, rc};
    s3 = lanes_in[3];
    s4 = lanes_in[4];
    // Bit-sliced 5-bit S-box.
    s0 = s0 ^ s4;
    s4 = s4 ^ s3;
    s2 = s2 ^ s1;
    t0 = ~s0 & s1;
    t1 = ~s1 & s2;
    t2 = ~s2 & s3;
    t3 = ~s3 & s4;
    t4 = ~s4 & s0;
    s0 = s0 ^ t1;
    s1 = s1 ^ t2;
    s2 = s2 ^ t3;
    s3 = s3 ^ t4;
    s4 = s4 ^ t0;
    s1 = s1 ^ s0;
    s0 = s0 ^ s4;
    s3 = s3 ^ s2;
    s2 = ~s2;
    // Linear diffusion per lane.
    lanes_out[0] = s0 ^ ror64(s0, 19) ^ ror64(s0, 28);
    lanes_out[1] = s1 ^ ror64(s1, 61) ^ ror64(s1, 39);
    lanes_out[2] = s2 ^ ror64(s2, 1)  ^ ror64(s2, 6);
    lanes_out[3] = s3 ^ ror64(s3, 10) ^ ror64(s3, 17);
    lanes_out[4] = s4 ^ ror64(s4, 7)  ^ ror64(s4, 41);
  end

endmodule

### sv/ascon_checker.sv
// ============================================================================
// ascon_checker
// Port-level checks of the Ascon-128 core, bound to the top level.
// ============================================================================
module ascon_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] data_out,
  input logic [3:0]  data_bytes,
  input logic [63:0] tag_high,
  input logic [63:0] tag_low,
  input logic        tag_valid,
  input logic        tag_match
);

  // The core works on one request at a time, so it is busy right after one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request channel open right after an accepted request");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(data_out)
                                  && $stable(tag_valid)))
    else $error("stalled result changed");

  // The final block of a message carries at most seven bytes.
  a_tag_block_short: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tag_valid) |-> (data_bytes < 4'd8))
    else $error("tag delivered with a full data block");

  // Without a tag, the tag fields and match flag are zero.
  a_tag_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tag_valid) |-> (tag_high == 64'd0 && tag_low == 64'd0
                                   && !tag_match))
    else $error("tag fields set without a finished tag");

endmodule

bind ascon128_aead_core_top ascon_checker u_ascon_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .data_out   (data_out),
  .data_bytes (data_bytes),
  .tag_high   (tag_high),
  .tag_low    (tag_low),
  .tag_valid  (tag_valid),
  .tag_match  (tag_match)
);
